### rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants for the Euler angle to quaternion converter
// Holds the fixed-point formats, the CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int AngW        = 16;
    localparam int QuatW       = 16;
    localparam int CordW       = 34;           // Q3.30 covers the folded angle range
    localparam int DefIters    = 16;
    localparam int MaxIters    = 32;

    localparam logic signed [CordW-1:0] Q30Pi     = 34'sd3373259426;
    localparam logic signed [CordW-1:0] Q30HalfPi = 34'sd1686629713;
    localparam logic signed [CordW-1:0] Q30Gain   = 34'sd652032874;
    localparam logic signed [QuatW-1:0] Q14One    = 16'sd16384;

    // Arctangent of 2^-i in Q30, rounded to nearest.
    function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CordW-1:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sd843314857;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd10: v = 34'sd1048576;
                5'd11: v = 34'sd524288;
                5'd12: v = 34'sd262144;
                5'd13: v = 34'sd131072;
                5'd14: v = 34'sd65536;
                5'd15: v = 34'sd32768;
                5'd16: v = 34'sd16384;
                5'd17: v = 34'sd8192;
                5'd18: v = 34'sd4096;
                5'd19: v = 34'sd2048;
                5'd20: v = 34'sd1024;
                5'd21: v = 34'sd512;
                5'd22: v = 34'sd256;
                5'd23: v = 34'sd128;
                5'd24: v = 34'sd64;
                5'd25: v = 34'sd32;
                5'd26: v = 34'sd16;
                5'd27: v = 34'sd8;
                5'd28: v = 34'sd4;
                5'd29: v = 34'sd2;
                default: v = 34'sd1;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/e2q_cordic_lane.sv
// ----------------------------------------------------------------------------
// e2q_cordic_lane: pipelined half-angle cosine and sine
// One angle enters per cycle while i_en is high. A fold stage is followed by
// one register stage per CORDIC step. Stages advance together on shared i_en.
// ----------------------------------------------------------------------------
module e2q_cordic_lane #(
    parameter int ITERS = e2q_pkg::DefIters
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [e2q_pkg::AngW-1:0]      i_angle,
    output logic signed [e2q_pkg::CordW-1:0]     o_cos,
    output logic signed [e2q_pkg::CordW-1:0]     o_sin
);

    localparam int W  = e2q_pkg::CordW;
    localparam int NI = (ITERS > e2q_pkg::MaxIters) ? e2q_pkg::MaxIters : ITERS;

    logic signed [W-1:0] r_x [NI+1];
    logic signed [W-1:0] r_y [NI+1];
    logic signed [W-1:0] r_z [NI+1];
    logic                r_flip [NI+1];

    logic signed [W-1:0] n_z0;
    logic                n_flip0;

    // Half angle in Q30 and quadrant fold into -pi/2..pi/2.
    always_comb begin
        logic signed [W-1:0] z;
        z = {{(W-e2q_pkg::AngW-16){i_angle[e2q_pkg::AngW-1]}}, i_angle, 16'd0};
        n_flip0 = 1'b0;
        n_z0    = z;
        if (z > e2q_pkg::Q30HalfPi) begin
            n_z0    = z - e2q_pkg::Q30Pi;
            n_flip0 = 1'b1;
        end else if (z < -e2q_pkg::Q30HalfPi) begin
            n_z0    = z + e2q_pkg::Q30Pi;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= e2q_pkg::Q30Gain;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
        end
    end

    // One rotation step per stage.
    for (genvar g = 0; g < NI; g++) begin : g_step
        logic signed [W-1:0] dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][W-1]) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - e2q_pkg::atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + e2q_pkg::atan_q30(5'(g));
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    assign o_cos = r_flip[NI] ? -r_x[NI] : r_x[NI];
    assign o_sin = r_flip[NI] ? -r_y[NI] : r_y[NI];

endmodule

### rtl/e2q_merge.sv
// ----------------------------------------------------------------------------
// e2q_merge: triple-product combiner
// Forms the four quaternion components from three cos/sin pairs in three
// register stages: pair product, triple product, then sum, round and saturate.
// ----------------------------------------------------------------------------
module e2q_merge (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [e2q_pkg::CordW-1:0]     i_cr,
    input  logic signed [e2q_pkg::CordW-1:0]     i_sr,
    input  logic signed [e2q_pkg::CordW-1:0]     i_cp,
    input  logic signed [e2q_pkg::CordW-1:0]     i_sp,
    input  logic signed [e2q_pkg::CordW-1:0]     i_cy,
    input  logic signed [e2q_pkg::CordW-1:0]     i_sy,
    output logic signed [e2q_pkg::QuatW-1:0]     o_w,
    output logic signed [e2q_pkg::QuatW-1:0]     o_x,
    output logic signed [e2q_pkg::QuatW-1:0]     o_y,
    output logic signed [e2q_pkg::QuatW-1:0]     o_z
);

    localparam int W  = e2q_pkg::CordW;
    localparam int PW = 2*W;
    localparam int SW = PW + 1;

    // Pair products cr*cp, sr*sp, sr*cp, cr*sp, floored to Q30.
    logic signed [W-1:0] r_cc, r_ss, r_sc, r_cs, r_cy, r_sy;
    logic signed [PW-1:0] p_cc, p_ss, p_sc, p_cs;
    assign p_cc = i_cr * i_cp;
    assign p_ss = i_sr * i_sp;
    assign p_sc = i_sr * i_cp;
    assign p_cs = i_cr * i_sp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= W'(p_cc >>> 30);
            r_ss <= W'(p_ss >>> 30);
            r_sc <= W'(p_sc >>> 30);
            r_cs <= W'(p_cs >>> 30);
            r_cy <= i_cy;
            r_sy <= i_sy;
        end
    end

    // Triple products in Q60.
    logic signed [PW-1:0] r_t [8];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= r_cc * r_cy;
            r_t[1] <= r_ss * r_sy;
            r_t[2] <= r_sc * r_cy;
            r_t[3] <= r_cs * r_sy;
            r_t[4] <= r_cs * r_cy;
            r_t[5] <= r_sc * r_sy;
            r_t[6] <= r_cc * r_sy;
            r_t[7] <= r_ss * r_cy;
        end
    end

    function automatic logic signed [e2q_pkg::QuatW-1:0] to_q14(
        input logic signed [SW-1:0] s);
        logic signed [SW-1:0] r;
        begin
            r = (s + (SW'(1) <<< 45)) >>> 46;
            if (r > SW'(e2q_pkg::Q14One))
                r = SW'(e2q_pkg::Q14One);
            if (r < -SW'(e2q_pkg::Q14One))
                r = -SW'(e2q_pkg::Q14One);
            return r[e2q_pkg::QuatW-1:0];
        end
    endfunction

    // Sums, rounding and saturation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= to_q14(SW'(r_t[0]) + SW'(r_t[1]));
            o_x <= to_q14(SW'(r_t[2]) - SW'(r_t[3]));
            o_y <= to_q14(SW'(r_t[4]) + SW'(r_t[5]));
            o_z <= to_q14(SW'(r_t[6]) - SW'(r_t[7]));
        end
    end

endmodule

### rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll, pitch and yaw to unit quaternion
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_roll_angle, i_pitch_angle, i_yaw_angle
//   output   out        o_valid / i_stall    o_quat_w, o_quat_x, o_quat_y, o_quat_z
//
// One item is accepted per cycle while o_stall is low. The pipeline has one stage
// for the fold, one per CORDIC step (CORDIC_ITERATIONS, at most MaxIters) in each
// of the three angle lanes, and three in the product merge.
// The pipeline moves as a whole and holds while a result waits under stall,
// so the input is stalled only when the output is stalled and full.
// Reset clears the valid bits of the pipeline only.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
    parameter int CORDIC_ITERATIONS = e2q_pkg::DefIters
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [e2q_pkg::AngW-1:0]   i_roll_angle,
    input  logic signed [e2q_pkg::AngW-1:0]   i_pitch_angle,
    input  logic signed [e2q_pkg::AngW-1:0]   i_yaw_angle,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [e2q_pkg::QuatW-1:0]  o_quat_w,
    output logic signed [e2q_pkg::QuatW-1:0]  o_quat_x,
    output logic signed [e2q_pkg::QuatW-1:0]  o_quat_y,
    output logic signed [e2q_pkg::QuatW-1:0]  o_quat_z
);

    localparam int NI = (CORDIC_ITERATIONS > e2q_pkg::MaxIters) ?
                        e2q_pkg::MaxIters : CORDIC_ITERATIONS;
    localparam int LAT = NI + 4;

    logic signed [e2q_pkg::CordW-1:0] cr, sr, cp, sp, cy, sy;
    logic [LAT-1:0] r_vld;
    logic           en;

    // The whole pipeline advances unless a finished item is held.
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Three angle lanes side by side.
    e2q_cordic_lane #(.ITERS(NI)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(i_roll_angle), .o_cos(cr), .o_sin(sr));
    e2q_cordic_lane #(.ITERS(NI)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(i_pitch_angle), .o_cos(cp), .o_sin(sp));
    e2q_cordic_lane #(.ITERS(NI)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(i_yaw_angle), .o_cos(cy), .o_sin(sy));

    // Merge the lanes into the four components.
    e2q_merge u_merge (
        .i_clk(i_clk), .i_en(en),
        .i_cr(cr), .i_sr(sr), .i_cp(cp), .i_sp(sp), .i_cy(cy), .i_sy(sy),
        .o_w(o_quat_w), .o_x(o_quat_x), .o_y(o_quat_y), .o_z(o_quat_z));

endmodule

### test/tb_euler_to_quaternion.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion: self-checking bench for the Euler angle converter
// Drives roll, pitch and yaw items with random idling on both channels,
// predicts each quaternion with a bit-exact CORDIC and product model, and
// compares every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion;

    localparam int Iters = e2q_pkg::DefIters;
    localparam int Latency = Iters + 4;
    localparam int WatchLimit = 2000;

    typedef struct packed {
        logic signed [e2q_pkg::QuatW-1:0] w;
        logic signed [e2q_pkg::QuatW-1:0] x;
        logic signed [e2q_pkg::QuatW-1:0] y;
        logic signed [e2q_pkg::QuatW-1:0] z;
    } t_quat;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic signed [e2q_pkg::AngW-1:0] i_roll_angle;
    logic signed [e2q_pkg::AngW-1:0] i_pitch_angle;
    logic signed [e2q_pkg::AngW-1:0] i_yaw_angle;
    logic o_valid;
    logic i_stall;
    logic signed [e2q_pkg::QuatW-1:0] o_quat_w;
    logic signed [e2q_pkg::QuatW-1:0] o_quat_x;
    logic signed [e2q_pkg::QuatW-1:0] o_quat_y;
    logic signed [e2q_pkg::QuatW-1:0] o_quat_z;

    t_quat pending_quats[$];
    int    error_count;
    int    idle_cycles;
    bit    idling_on;

    euler_to_quaternion #(.CORDIC_ITERATIONS(Iters)) dut (.*);

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Floor division by a power of two.
    function automatic longint floor_div(input longint v, input int s);
        return v >>> s;
    endfunction

    // Cosine and sine in Q30 of half the Q3.13 angle.
    function automatic void half_angle_trig(input logic signed [e2q_pkg::AngW-1:0] ang,
                                            output longint c, output longint s);
        longint zq, xq, yq, dx, dy, tbl;
        bit     flip;
        int     n;
        zq = longint'(ang) * 65536;
        xq = longint'(e2q_pkg::Q30Gain);
        yq = 0;
        flip = 1'b0;
        n = (Iters > e2q_pkg::MaxIters) ? e2q_pkg::MaxIters : Iters;
        if (zq > longint'(e2q_pkg::Q30HalfPi)) begin
            zq -= longint'(e2q_pkg::Q30Pi);
            flip = 1'b1;
        end else if (zq < -longint'(e2q_pkg::Q30HalfPi)) begin
            zq += longint'(e2q_pkg::Q30Pi);
            flip = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            dx = floor_div(yq, i);
            dy = floor_div(xq, i);
            tbl = longint'(e2q_pkg::atan_q30(i[4:0]));
            if (zq >= 0) begin
                xq -= dx;
                yq += dy;
                zq -= tbl;
            end else begin
                xq += dx;
                yq -= dy;
                zq += tbl;
            end
        end
        c = flip ? -xq : xq;
        s = flip ? -yq : yq;
    endfunction

    // Q60 sum of triple products rounded to Q14 with saturation.
    function automatic logic signed [e2q_pkg::QuatW-1:0] round_q14(
        input longint a, input longint b, input longint c,
        input longint d, input longint e, input longint f, input bit sub);
        longint t1, t2, r;
        t1 = floor_div(a * b, 30) * c;
        t2 = floor_div(d * e, 30) * f;
        r = floor_div((sub ? t1 - t2 : t1 + t2) + (longint'(1) <<< 45), 46);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[e2q_pkg::QuatW-1:0];
    endfunction

    function automatic t_quat predict_quat(input logic signed [e2q_pkg::AngW-1:0] roll,
                                           input logic signed [e2q_pkg::AngW-1:0] pitch,
                                           input logic signed [e2q_pkg::AngW-1:0] yaw);
        longint cr, sr, cp, sp, cy, sy;
        t_quat q;
        half_angle_trig(roll, cr, sr);
        half_angle_trig(pitch, cp, sp);
        half_angle_trig(yaw, cy, sy);
        q.w = round_q14(cr, cp, cy, sr, sp, sy, 1'b0);
        q.x = round_q14(sr, cp, cy, cr, sp, sy, 1'b1);
        q.y = round_q14(cr, sp, cy, sr, cp, sy, 1'b0);
        q.z = round_q14(cr, cp, sy, sr, sp, cy, 1'b1);
        return q;
    endfunction

    // Send one item, with a random idle burst ahead of it when idling is on.
    task automatic send_angles(input logic signed [e2q_pkg::AngW-1:0] roll,
                               input logic signed [e2q_pkg::AngW-1:0] pitch,
                               input logic signed [e2q_pkg::AngW-1:0] yaw);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_roll_angle  <= roll;
        i_pitch_angle <= pitch;
        i_yaw_angle   <= yaw;
        do @(posedge i_clk); while (o_stall);
        pending_quats.push_back(predict_quat(roll, pitch, yaw));
    endtask

    function automatic logic [e2q_pkg::AngW-1:0] random_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(int'($urandom_range(0, 25736)) - 12868);  // within +-pi/2
            2: return 16'(int'($urandom_range(0, 400)) - 200);      // near zero
            default: return 16'(int'($urandom_range(0, 400)) + 12668); // near pi/2
        endcase
    endfunction

    // Extremes of each field, quadrant boundaries and near-saturation points.
    task automatic test_directed();
        logic signed [e2q_pkg::AngW-1:0] corners[10] = '{16'sh0000, 16'sh7fff,
            16'sh8000, 16'sh0001, 16'shffff, 16'sd12868, -16'sd12868, 16'sd12869,
            -16'sd12869, 16'sd25736};
        foreach (corners[k]) send_angles(corners[k], 16'sh0000, 16'sh0000);
        send_angles(16'sh0000, 16'sh7fff, 16'sh8000);
        send_angles(16'sh8000, 16'sh0000, 16'sh7fff);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sd12868, 16'sd12868, 16'sd12868);
        send_angles(-16'sd12868, 16'sd6434, -16'sd6434);
        send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
        send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_angles(random_angle(), random_angle(), random_angle());
    endtask

    // Back-to-back items with no idling on either side.
    task automatic test_streaming(input int count);
        idling_on = 1'b0;
        repeat (count) send_angles(random_angle(), random_angle(), random_angle());
    endtask

    // Output stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n || !idling_on) begin
            i_stall <= 1'b0;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            idle_cycles <= $urandom_range(0, 3);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_quats.size() == 0) begin
                $error("unexpected result w=%0d x=%0d y=%0d z=%0d",
                       o_quat_w, o_quat_x, o_quat_y, o_quat_z);
                error_count++;
            end else begin
                exp_q = pending_quats.pop_front();
                if (o_quat_w !== exp_q.w) begin
                    $error("quat_w expected %0d actual %0d", exp_q.w, o_quat_w);
                    error_count++;
                end
                if (o_quat_x !== exp_q.x) begin
                    $error("quat_x expected %0d actual %0d", exp_q.x, o_quat_x);
                    error_count++;
                end
                if (o_quat_y !== exp_q.y) begin
                    $error("quat_y expected %0d actual %0d", exp_q.y, o_quat_y);
                    error_count++;
                end
                if (o_quat_z !== exp_q.z) begin
                    $error("quat_z expected %0d actual %0d", exp_q.z, o_quat_z);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either channel.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WatchLimit) begin
                $display("tb_euler_to_quaternion: FAIL");
                $finish;
            end
        end
    end

    initial begin
        error_count   = 0;
        idling_on     = 1'b1;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_roll_angle  = '0;
        i_pitch_angle = '0;
        i_yaw_angle   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(800);
        test_streaming(200);
        i_valid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        if (error_count == 0) $display("tb_euler_to_quaternion: PASS");
        else $display("tb_euler_to_quaternion: FAIL");
        $finish;
    end
endmodule

### filelist.f
rtl/e2q_pkg.sv
rtl/e2q_cordic_lane.sv
rtl/e2q_merge.sv
rtl/euler_to_quaternion.sv
test/tb_euler_to_quaternion.sv
